// ===== hdl/ffn_pkg.sv =====
// Shared types, constants and GELU table arithmetic for the feed-forward block.
package ffn_pkg;

    localparam int DEF_EMB_DIM          = 16;
    localparam int DEF_HIDDEN_MULT      = 4;
    localparam int DEF_GELU_TABLE_DEPTH = 256;

    // Width of one GELU table point (signed Q4.16, magnitude up to 8.0)
    localparam int TBL_W = 21;

    localparam logic [2:0] OP_ROW = 3'd0;
    localparam logic [2:0] OP_W1  = 3'd1;
    localparam logic [2:0] OP_W2  = 3'd2;
    localparam logic [2:0] OP_B1  = 3'd3;
    localparam logic [2:0] OP_B2  = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [9:0]         index;
        logic signed [15:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] result;
        logic [3:0]         column;
        logic               last;
    } t_out_beat;

    // Control that travels with one product into an accumulator chain
    typedef struct packed {
        logic en;
        logic first;
        logic last;
    } t_mac;

    // Control of one issued multiply-accumulate step
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic ph;
    } t_iss;

    localparam longint ONE_Q16       = 64'sd65536;
    localparam longint ONE_Q30       = 64'sd1073741824;
    localparam longint EXP_M1_Q30    = 64'sd395007543;
    localparam longint SQRT_2_PI_Q24 = 64'sd13386282;
    localparam longint CUBIC_COEF_Q24 = 64'sd750193;

    // Signed quotient truncated toward zero, by shift and subtract; elaboration only
    function automatic longint div_trunc(input longint a, input longint b);
        longint ua;
        longint ub;
        longint q;
        longint rem;
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        q   = 0;
        rem = 0;
        for (int k = 62; k >= 0; k--) begin
            rem = (rem <<< 1) | ((ua >>> k) & 64'sd1);
            if (rem >= ub) begin
                rem = rem - ub;
                q   = q | (64'sd1 <<< k);
            end
        end
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    // exp(-t) in Q30, t in Q16 below 16.0; evaluated at elaboration only
    function automatic longint exp_neg_q30(input longint t);
        longint n;
        longint r;
        longint term;
        longint sum;
        n    = t >>> 16;
        r    = t & 64'sd65535;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int k = 1; k <= 12; k++) begin
            term = div_trunc(-(term * r), longint'(k) * ONE_Q16);
            sum  = sum + term;
        end
        for (longint k = 0; k < n; k++) begin
            sum = (sum * EXP_M1_Q30 + 64'sd536870912) >>> 30;
        end
        return sum;
    endfunction

    function automatic longint tanh_q16(input longint u);
        longint e;
        if (u >= 8 * ONE_Q16) begin
            return ONE_Q16;
        end
        e = exp_neg_q30(2 * u);
        return div_trunc((ONE_Q30 - e) <<< 16, ONE_Q30 + e);
    endfunction

    function automatic longint gelu_q16(input longint x);
        longint ax;
        longint sq;
        longint cube;
        longint inr;
        longint u;
        longint th;
        ax   = (x < 0) ? -x : x;
        sq   = (ax * ax) >>> 16;
        cube = (sq * ax) >>> 16;
        inr  = ax + ((cube * CUBIC_COEF_Q24) >>> 24);
        u    = (inr * SQRT_2_PI_Q24) >>> 24;
        th   = tanh_q16(u);
        if (x >= 0) begin
            return (ax * (ONE_Q16 + th)) >>> 17;
        end
        return -((ax * (ONE_Q16 - th)) >>> 17);
    endfunction

    // Table point k of a table with depth segments
    function automatic longint gelu_point(input int k, input int depth);
        longint num;
        longint x;
        num = (64'sd4096 * longint'(k) - 64'sd2048 * longint'(depth)) * 64'sd256;
        x   = div_trunc(num, longint'(depth));
        return gelu_q16(x);
    endfunction

endpackage

// ===== hdl/transformer_ffn_gelu.sv =====
// Top level: transformer feed-forward layer with tanh-form GELU, one row at a time.
// Load beats and non-final row beats are taken while idle and leave the block ready for the next beat.
// The final row beat starts the multiply-accumulate steps on one shared multiplier, EMB*HID
// per layer; the second layer starts once the last hidden value is written. Results are then
// read from the output buffer and shown one at a time until taken, EMB beats per row.
// Reset (synchronous, active low) clears the sequencer and valid flags; memories keep contents.
module transformer_ffn_gelu import ffn_pkg::*; #(
    parameter int EMB_DIM          = DEF_EMB_DIM,
    parameter int HIDDEN_MULT      = DEF_HIDDEN_MULT,
    parameter int GELU_TABLE_DEPTH = DEF_GELU_TABLE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    localparam int HID_DIM = EMB_DIM * HIDDEN_MULT;
    localparam int W_SIZE  = EMB_DIM * HID_DIM;
    localparam int IW      = $clog2(EMB_DIM);
    localparam int HW      = $clog2(HID_DIM);
    localparam int WA      = $clog2(W_SIZE);
    localparam int ACC_W   = 34 + $clog2(HID_DIM);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;  // take load and row beats
    localparam logic [2:0] ST_H    = 3'd1;  // issue first-layer steps
    localparam logic [2:0] ST_HW   = 3'd2;  // wait for the last hidden value
    localparam logic [2:0] ST_O    = 3'd3;  // issue second-layer steps
    localparam logic [2:0] ST_OW   = 3'd4;  // wait for the last output value
    localparam logic [2:0] ST_DR   = 3'd5;  // read one result from the output buffer
    localparam logic [2:0] ST_DO   = 3'd6;  // present the result until taken

    logic [2:0]    r_state, n_state;
    logic [WA-1:0] r_a, n_a;
    logic [HW-1:0] r_ki, n_ki;
    logic [HW-1:0] r_kj, n_kj;
    logic [HW-1:0] r_hid_wa;
    logic [IW-1:0] r_out_wa;
    logic [IW-1:0] r_k, n_k;

    // Storage; contents undefined until written
    logic signed [15:0] r_w1_mem  [0:W_SIZE-1];
    logic signed [15:0] r_w2_mem  [0:W_SIZE-1];
    logic signed [15:0] r_b1_mem  [0:HID_DIM-1];
    logic signed [15:0] r_b2_mem  [0:EMB_DIM-1];
    logic signed [15:0] r_row_mem [0:EMB_DIM-1];
    logic signed [15:0] r_hid_mem [0:HID_DIM-1];
    logic signed [15:0] r_out_mem [0:EMB_DIM-1];

    logic signed [15:0] r_w1_rd, r_w2_rd, r_b1_rd, r_b2_rd;
    logic signed [15:0] r_row_rd, r_hid_rd, r_out_rd;

    t_iss               w_iss;
    t_iss               r_a_ctl, r_b_ctl;
    logic signed [31:0] r_prod;
    logic signed [15:0] r_bias;
    t_mac               w_mac1, w_mac2;

    logic               w_r1_v, w_r2_v, w_g_v;
    logic signed [15:0] w_r1_res, w_r2_res, w_g_y;

    logic w_in_acc, w_out_acc;
    logic w_row_ok, w_trigger;
    logic w_i_end, w_j_end;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_out_acc  = o_out_valid & i_out_ready;

    assign w_row_ok  = (32'(i_in.index) < EMB_DIM);
    assign w_trigger = w_in_acc && (i_in.op == OP_ROW) && (32'(i_in.index) == EMB_DIM - 1);

    // Inner and outer limits differ between the two layers
    assign w_j_end = (r_state == ST_O) ? (r_kj == HW'(EMB_DIM - 1)) : (r_kj == HW'(HID_DIM - 1));
    assign w_i_end = (r_state == ST_O) ? (r_ki == HW'(HID_DIM - 1)) : (r_ki == HW'(EMB_DIM - 1));

    always_comb begin
        w_iss.valid = (r_state == ST_H) || (r_state == ST_O);
        w_iss.first = (r_ki == '0);
        w_iss.last  = w_i_end;
        w_iss.ph    = (r_state == ST_O);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_ki    = r_ki;
        n_kj    = r_kj;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (w_trigger) begin
                    n_state = ST_H;
                    n_a     = '0;
                    n_ki    = '0;
                    n_kj    = '0;
                end
            end
            ST_H, ST_O: begin
                n_a = r_a + WA'(1);
                if (w_j_end) begin
                    n_kj = '0;
                    n_ki = r_ki + HW'(1);
                    if (w_i_end) begin
                        n_state = (r_state == ST_H) ? ST_HW : ST_OW;
                    end
                end else begin
                    n_kj = r_kj + HW'(1);
                end
            end
            ST_HW: begin
                if (w_g_v && (r_hid_wa == HW'(HID_DIM - 1))) begin
                    n_state = ST_O;
                    n_a     = '0;
                    n_ki    = '0;
                    n_kj    = '0;
                end
            end
            ST_OW: begin
                if (w_r2_v && (r_out_wa == IW'(EMB_DIM - 1))) begin
                    n_state = ST_DR;
                    n_k     = '0;
                end
            end
            ST_DR: begin
                n_state = ST_DO;
            end
            ST_DO: begin
                if (w_out_acc) begin
                    if (r_k == IW'(EMB_DIM - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_DR;
                        n_k     = r_k + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_a      <= '0;
            r_ki     <= '0;
            r_kj     <= '0;
            r_k      <= '0;
            r_hid_wa <= '0;
            r_out_wa <= '0;
            r_a_ctl  <= '0;
            r_b_ctl  <= '0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_ki    <= n_ki;
            r_kj    <= n_kj;
            r_k     <= n_k;
            r_a_ctl <= w_iss;
            r_b_ctl <= r_a_ctl;
            // Restart write pointers with each row
            if (w_trigger) begin
                r_hid_wa <= '0;
                r_out_wa <= '0;
            end else begin
                if (w_g_v) begin
                    r_hid_wa <= r_hid_wa + HW'(1);
                end
                if (w_r2_v) begin
                    r_out_wa <= r_out_wa + IW'(1);
                end
            end
        end
    end

    // Memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.op == OP_W1) && (32'(i_in.index) < W_SIZE)) begin
            r_w1_mem[WA'(i_in.index)] <= i_in.value;
        end
        r_w1_rd <= r_w1_mem[r_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.op == OP_W2) && (32'(i_in.index) < W_SIZE)) begin
            r_w2_mem[WA'(i_in.index)] <= i_in.value;
        end
        r_w2_rd <= r_w2_mem[r_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.op == OP_B1) && (32'(i_in.index) < HID_DIM)) begin
            r_b1_mem[HW'(i_in.index)] <= i_in.value;
        end
        r_b1_rd <= r_b1_mem[r_kj];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.op == OP_B2) && w_row_ok) begin
            r_b2_mem[IW'(i_in.index)] <= i_in.value;
        end
        r_b2_rd <= r_b2_mem[r_kj[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.op == OP_ROW) && w_row_ok) begin
            r_row_mem[IW'(i_in.index)] <= i_in.value;
        end
        r_row_rd <= r_row_mem[r_ki[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_g_v) begin
            r_hid_mem[r_hid_wa] <= w_g_y;
        end
        r_hid_rd <= r_hid_mem[r_ki];
    end

    always_ff @(posedge i_clk) begin
        if (w_r2_v) begin
            r_out_mem[r_out_wa] <= w_r2_res;
        end
        r_out_rd <= r_out_mem[r_k];
    end

    // Shared multiplier: operands follow the layer of the step
    always_ff @(posedge i_clk) begin
        if (r_a_ctl.ph) begin
            r_prod <= 32'(r_hid_rd) * 32'(r_w2_rd);
            r_bias <= r_b2_rd;
        end else begin
            r_prod <= 32'(r_row_rd) * 32'(r_w1_rd);
            r_bias <= r_b1_rd;
        end
    end

    always_comb begin
        w_mac1.en    = r_b_ctl.valid & ~r_b_ctl.ph;
        w_mac1.first = r_b_ctl.first;
        w_mac1.last  = r_b_ctl.last;
        w_mac2.en    = r_b_ctl.valid & r_b_ctl.ph;
        w_mac2.first = r_b_ctl.first;
        w_mac2.last  = r_b_ctl.last;
    end

    // First layer: one accumulator per hidden column
    ffn_ring #(.N(HID_DIM), .ACC_W(ACC_W)) u_ring_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mac   (w_mac1),
        .i_prod  (r_prod),
        .i_bias  (r_bias),
        .o_valid (w_r1_v),
        .o_res   (w_r1_res)
    );

    ffn_gelu #(.GELU_TABLE_DEPTH(GELU_TABLE_DEPTH)) u_gelu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_r1_v),
        .i_x     (w_r1_res),
        .o_valid (w_g_v),
        .o_y     (w_g_y)
    );

    // Second layer: one accumulator per output column
    ffn_ring #(.N(EMB_DIM), .ACC_W(ACC_W)) u_ring_o (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mac   (w_mac2),
        .i_prod  (r_prod),
        .i_bias  (r_bias),
        .o_valid (w_r2_v),
        .o_res   (w_r2_res)
    );

    // Output beat comes straight from the buffer read register
    assign o_out_valid   = (r_state == ST_DO);
    assign o_out.result  = r_out_rd;
    assign o_out.column  = 4'(r_k);
    assign o_out.last    = (r_k == IW'(EMB_DIM - 1));

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is shown");

    a_gelu_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_g_v |-> (r_state == ST_H || r_state == ST_HW))
        else $error("hidden value outside first layer");

    a_out_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_r2_v |-> (r_state == ST_O || r_state == ST_OW))
        else $error("output value outside second layer");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last) |=> o_in_ready)
        else $error("block not ready after last result");

endmodule

// ===== hdl/ffn_cell.sv =====
// One accumulator cell of the chain: hold a partial sum, hand it on when enabled.
module ffn_cell import ffn_pkg::*; #(
    parameter int ACC_W = 48
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ACC_W-1:0] i_d,
    output logic signed [ACC_W-1:0] o_q
);

    logic signed [ACC_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hdl/ffn_gelu.sv =====
// Pipelined GELU: table lookup with linear interpolation, four stages.
module ffn_gelu import ffn_pkg::*; #(
    parameter int GELU_TABLE_DEPTH = DEF_GELU_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_x,
    output logic               o_valid,
    output logic signed [15:0] o_y
);

    localparam int SW = $clog2(GELU_TABLE_DEPTH + 1);
    localparam int PW = 12 + SW;
    localparam int MW = TBL_W + 14;
    localparam int SUM_W = MW + 1;

    logic signed [TBL_W-1:0] w_tbl [0:GELU_TABLE_DEPTH];

    for (genvar k = 0; k <= GELU_TABLE_DEPTH; k++) begin : g_tbl
        localparam logic signed [TBL_W-1:0] PT = TBL_W'(gelu_point(k, GELU_TABLE_DEPTH));
        assign w_tbl[k] = PT;
    end

    logic [2:0]              r_v;
    logic signed [15:0]      r1_x, r2_x, r3_x;
    logic                    r1_big, r2_big, r3_big;
    logic                    r1_neg, r2_neg, r3_neg;
    logic [SW-1:0]           r1_seg;
    logic [11:0]             r1_frac, r2_frac;
    logic signed [TBL_W-1:0] r2_p0, r2_p1;
    logic signed [MW-1:0]    r3_m0, r3_m1;
    logic                    r_ov;
    logic signed [15:0]      r_y;

    logic [11:0]             w_off;
    logic [PW-1:0]           w_pos;
    logic [SW-1:0]           w_seg1;
    logic [12:0]             w_c0;
    logic signed [SUM_W-1:0] w_s;
    logic signed [SUM_W-1:0] w_sh;
    logic signed [15:0]      w_sat;

    assign w_off  = 12'(17'(i_x) + 17'sd2048);
    assign w_pos  = PW'(w_off) * PW'(GELU_TABLE_DEPTH);
    assign w_seg1 = r1_seg + SW'(1);
    assign w_c0   = 13'd4096 - 13'(r2_frac);
    assign w_s    = SUM_W'(r3_m0) + SUM_W'(r3_m1) + SUM_W'(64'sd524288);
    assign w_sh   = w_s >>> 20;

    always_comb begin
        if (w_sh > SUM_W'(32767)) begin
            w_sat = 16'sh7fff;
        end else if (w_sh < SUM_W'(-32768)) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = 16'(w_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            r_v  <= {r_v[1:0], i_valid};
            r_ov <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x    <= i_x;
        r1_big  <= (i_x >= 16'sd2048);
        r1_neg  <= (i_x <= -16'sd2048);
        r1_seg  <= w_pos[PW-1:12];
        r1_frac <= w_pos[11:0];

        r2_x    <= r1_x;
        r2_big  <= r1_big;
        r2_neg  <= r1_neg;
        r2_frac <= r1_frac;
        r2_p0   <= w_tbl[r1_seg];
        r2_p1   <= w_tbl[w_seg1];

        r3_x    <= r2_x;
        r3_big  <= r2_big;
        r3_neg  <= r2_neg;
        r3_m0   <= MW'(r2_p0) * MW'($signed({1'b0, w_c0}));
        r3_m1   <= MW'(r2_p1) * MW'($signed({2'b0, r2_frac}));

        if (r3_big) begin
            r_y <= r3_x;
        end else if (r3_neg) begin
            r_y <= '0;
        end else begin
            r_y <= w_sat;
        end
    end

    assign o_valid = r_ov;
    assign o_y     = r_y;

endmodule

// ===== hdl/ffn_ring.sv =====
// Ring of accumulator cells fed by one product per enabled cycle; rounds and saturates the final pass.
module ffn_ring import ffn_pkg::*; #(
    parameter int N     = 16,
    parameter int ACC_W = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac               i_mac,
    input  logic signed [31:0] i_prod,
    input  logic signed [15:0] i_bias,
    output logic               o_valid,
    output logic signed [15:0] o_res
);

    logic signed [ACC_W-1:0] w_q [N];
    logic signed [ACC_W-1:0] w_base;
    logic signed [ACC_W-1:0] w_head;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [ACC_W-1:0] r_sum;
    logic                    r_sv;
    logic                    r_ov;
    logic signed [15:0]      r_res;

    // Start a fresh sum from the bias on the first pass, else take the oldest cell
    assign w_base = i_mac.first ? (ACC_W'(i_bias) <<< 8) : w_q[N-1];
    assign w_head = w_base + ACC_W'(i_prod);

    for (genvar k = 0; k < N; k++) begin : g_cell
        if (k == 0) begin : g_head
            ffn_cell #(.ACC_W(ACC_W)) u_cell (
                .i_clk (i_clk),
                .i_en  (i_mac.en),
                .i_d   (w_head),
                .o_q   (w_q[k])
            );
        end else begin : g_body
            ffn_cell #(.ACC_W(ACC_W)) u_cell (
                .i_clk (i_clk),
                .i_en  (i_mac.en),
                .i_d   (w_q[k-1]),
                .o_q   (w_q[k])
            );
        end
    end

    assign w_rnd = (r_sum + ACC_W'(128)) >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_sv <= i_mac.en & i_mac.last;
            r_ov <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= w_head;
        if (w_rnd > ACC_W'(32767)) begin
            r_res <= 16'sh7fff;
        end else if (w_rnd < ACC_W'(-32768)) begin
            r_res <= -16'sh8000;
        end else begin
            r_res <= 16'(w_rnd);
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

// ===== tb/transformer_ffn_gelu_tb.sv =====
// Self-checking testbench for the feed-forward GELU block: loads, rows and result checks.
`timescale 1ns / 100ps

module transformer_ffn_gelu_tb;
    import ffn_pkg::*;

    localparam int EMB   = DEF_EMB_DIM;
    localparam int HID   = DEF_EMB_DIM * DEF_HIDDEN_MULT;
    localparam int DEPTH = DEF_GELU_TABLE_DEPTH;
    localparam int WSIZE = EMB * HID;
    // Ops beyond the defined set; the block must drop them
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_ready;
    t_out_beat out_beat;

    transformer_ffn_gelu u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Shadow copies of the block's stores, updated as each beat is accepted
    logic signed [15:0] sh_w1 [WSIZE];
    logic signed [15:0] sh_w2 [WSIZE];
    logic signed [15:0] sh_b1 [HID];
    logic signed [15:0] sh_b2 [EMB];
    logic signed [15:0] sh_row [EMB];
    longint             gelu_tbl [DEPTH + 1];

    t_in_beat  pending_beats [$];
    t_out_beat expected_outs [$];
    bit        failed;
    int        results_seen;

    function automatic longint exp_decay_q30(input longint t);
        longint whole, part, term, acc;
        whole = t >>> 16;
        part  = t & 64'sd65535;
        term  = 64'sd1073741824;
        acc   = term;
        for (int k = 1; k <= 12; k++) begin
            term = -(term * part) / (longint'(k) * 64'sd65536);
            acc  = acc + term;
        end
        for (longint k = 0; k < whole; k++) begin
            acc = (acc * 64'sd395007543 + 64'sd536870912) >>> 30;
        end
        return acc;
    endfunction

    function automatic longint gelu_exact_q16(input longint x);
        longint ax, sq, cube, inr, u, th, e;
        ax   = (x < 0) ? -x : x;
        sq   = (ax * ax) >>> 16;
        cube = (sq * ax) >>> 16;
        inr  = ax + ((cube * 64'sd750193) >>> 24);
        u    = (inr * 64'sd13386282) >>> 24;
        if (u >= 64'sd524288) begin
            th = 64'sd65536;
        end else begin
            e  = exp_decay_q30(2 * u);
            th = ((64'sd1073741824 - e) <<< 16) / (64'sd1073741824 + e);
        end
        if (x >= 0) begin
            return (ax * (64'sd65536 + th)) >>> 17;
        end
        return -((ax * (64'sd65536 - th)) >>> 17);
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Table lookup with linear interpolation between neighbouring points
    function automatic logic signed [15:0] gelu_lookup(input logic signed [15:0] x);
        longint pos, seg, frac, v;
        if (x >= 2048) return x;
        if (x <= -2048) return 16'sd0;
        pos  = (longint'(x) + 2048) * DEPTH;
        seg  = pos >>> 12;
        frac = pos & 64'sd4095;
        v    = gelu_tbl[seg] * (4096 - frac) + gelu_tbl[seg + 1] * frac;
        return clip16((v + 64'sd524288) >>> 20);
    endfunction

    // Run both layers over the current row and queue the output beats
    task automatic compute_row_outputs();
        logic signed [15:0] hid [HID];
        longint             acc;
        t_out_beat          ob;
        for (int j = 0; j < HID; j++) begin
            acc = longint'(sh_b1[j]) * 256;
            for (int i = 0; i < EMB; i++) begin
                acc += longint'(sh_row[i]) * longint'(sh_w1[i * HID + j]);
            end
            hid[j] = gelu_lookup(clip16((acc + 128) >>> 8));
        end
        for (int j = 0; j < EMB; j++) begin
            acc = longint'(sh_b2[j]) * 256;
            for (int i = 0; i < HID; i++) begin
                acc += longint'(hid[i]) * longint'(sh_w2[i * EMB + j]);
            end
            ob.result = clip16((acc + 128) >>> 8);
            ob.column = j[3:0];
            ob.last   = (j == EMB - 1);
            expected_outs.push_back(ob);
        end
    endtask

    task automatic absorb_beat(input t_in_beat b);
        case (b.op)
            OP_W1: sh_w1[b.index] = b.value;
            OP_W2: sh_w2[b.index] = b.value;
            OP_B1: if (b.index < HID) sh_b1[b.index] = b.value;
            OP_B2: if (b.index < EMB) sh_b2[b.index] = b.value;
            OP_ROW: begin
                if (b.index < EMB) begin
                    sh_row[b.index] = b.value;
                    if (b.index == EMB - 1) compute_row_outputs();
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] near_zero(input int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_in_beat mk_beat(input logic [2:0] op, input int idx,
                                         input logic signed [15:0] v);
        t_in_beat b;
        b.op    = op;
        b.index = idx[9:0];
        b.value = v;
        return b;
    endfunction

    // Quiet end: no idling once few beats remain
    wire calm = (pending_beats.size() < 60);

    // ---------------- driver ----------------
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_beat  <= '0;
            gap_left <= 0;
        end else begin
            // Update the shadow state on each accepted beat
            if (in_valid && in_ready) absorb_beat(in_beat);
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    in_beat  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 10);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------
    int  stall_left;
    int  hold_left;
    bit  long_hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready      <= 1'b0;
            stall_left     <= 0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            // Long back-pressure: hold off so the block fills and stalls its input
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= EMB) begin
            long_hold_done <= 1'b1;
            hold_left      <= 3000;
            out_ready      <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_outs.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, out_beat);
                failed = 1'b1;
            end else begin
                want = expected_outs.pop_front();
                if (out_beat.result !== want.result) begin
                    $display("%0t: result mismatch, expected %0d, actual %0d",
                             $time, want.result, out_beat.result);
                    failed = 1'b1;
                end
                if (out_beat.column !== want.column) begin
                    $display("%0t: column mismatch, expected %0d, actual %0d",
                             $time, want.column, out_beat.column);
                    failed = 1'b1;
                end
                if (out_beat.last !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, want.last, out_beat.last);
                    failed = 1'b1;
                end
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        int num, xq, n_rand, skip;
        results_seen = 0;
        failed       = 1'b0;
        i_rst_n      = 1'b0;
        for (int k = 0; k <= DEPTH; k++) begin
            num = (4096 * k - 2048 * DEPTH) * 256;
            xq  = (num >= 0) ? num / DEPTH : -((-num) / DEPTH);
            gelu_tbl[k] = gelu_exact_q16(longint'(xq));
        end

        // Fill every weight and bias store once so no row reads an unwritten entry
        for (int a = 0; a < WSIZE; a++) pending_beats.push_back(mk_beat(OP_W1, a, near_zero(64)));
        for (int a = 0; a < WSIZE; a++) pending_beats.push_back(mk_beat(OP_W2, a, near_zero(64)));
        for (int a = 0; a < HID; a++) pending_beats.push_back(mk_beat(OP_B1, a, near_zero(256)));
        for (int a = 0; a < EMB; a++) pending_beats.push_back(mk_beat(OP_B2, a, near_zero(256)));

        // Directed: extremes, ignored ops and out-of-range indices
        pending_beats.push_back(mk_beat(OP_B2, EMB - 1, 16'sh7fff));
        pending_beats.push_back(mk_beat(OP_B1, HID - 1, 16'sh8000));
        pending_beats.push_back(mk_beat(OP_SPARE_LO, EMB - 1, 16'sh7fff));
        pending_beats.push_back(mk_beat(OP_SPARE_MID, 0, 16'sh8000));
        pending_beats.push_back(mk_beat(OP_SPARE_HI, 1023, 16'shffff));
        pending_beats.push_back(mk_beat(OP_B1, HID, 16'sh1234));
        pending_beats.push_back(mk_beat(OP_B2, EMB, 16'sh4321));
        pending_beats.push_back(mk_beat(OP_B2, 1023, 16'sh7fff));
        pending_beats.push_back(mk_beat(OP_ROW, EMB, 16'sh7fff));
        pending_beats.push_back(mk_beat(OP_ROW, 1023, 16'sh8000));
        pending_beats.push_back(mk_beat(OP_W1, WSIZE - 1, 16'sh7fff));
        pending_beats.push_back(mk_beat(OP_W2, 0, 16'sh8000));
        // Zero row, then a saturating row of alternating extremes
        for (int c = 0; c < EMB; c++) pending_beats.push_back(mk_beat(OP_ROW, c, 16'sd0));
        for (int c = 0; c < EMB; c++)
            pending_beats.push_back(mk_beat(OP_ROW, c, c[0] ? 16'sh8000 : 16'sh7fff));

        // Random: mostly well-formed rows with a few weight and bias updates, some noise
        n_rand = 0;
        while (n_rand < 150) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(0, 4)) begin
                    case ($urandom_range(0, 3))
                        0: pending_beats.push_back(mk_beat(OP_W1,
                               $urandom_range(0, WSIZE - 1), near_zero(128)));
                        1: pending_beats.push_back(mk_beat(OP_W2,
                               $urandom_range(0, WSIZE - 1), near_zero(128)));
                        2: pending_beats.push_back(mk_beat(OP_B1,
                               $urandom_range(0, HID - 1), near_zero(2048)));
                        default: pending_beats.push_back(mk_beat(OP_B2,
                               $urandom_range(0, EMB - 1), 16'($urandom)));
                    endcase
                    n_rand++;
                end
                skip = $urandom_range(0, 3);
                for (int c = 0; c < EMB; c++) begin
                    // Leave some elements as they were; the final one always fires
                    if (c == EMB - 1 || $urandom_range(0, 7) >= skip) begin
                        pending_beats.push_back(mk_beat(OP_ROW, c,
                            ($urandom_range(0, 9) == 0) ? 16'($urandom) : near_zero(600)));
                        n_rand++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    pending_beats.push_back(mk_beat(3'($urandom_range(0, 7)),
                        $urandom_range(0, 1023), 16'($urandom)));
                    n_rand++;
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (pending_beats.size() != 0 || in_valid);
        do @(posedge i_clk); while (expected_outs.size() != 0);
        repeat (200) @(posedge i_clk);
        if (!failed) begin
            $display("transformer_ffn_gelu test passed");
        end else begin
            $display("transformer_ffn_gelu test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("transformer_ffn_gelu test failed");
        $finish;
    end

endmodule
